[sv/multi_alarm_timer_assert.svh]
// Assertion macros for the multi alarm timer.
// Each macro expects a signal named clock in the enclosing scope; the two muted ones also use reset.
`ifndef MULTI_ALARM_TIMER_ASSERT_SVH
`define MULTI_ALARM_TIMER_ASSERT_SVH

// Same-cycle implication, muted during reset
`define MAT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted during reset
`define MAT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also runs through reset
`define MAT_ASSERT_ANY_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/mat_pkg.sv]
`timescale 1ns / 1ps

package mat_pkg;

   localparam int NUM_ALARMS_DEF = 4;
   localparam int TIME_W         = 64;
   localparam int PERIOD_W       = 32;
   localparam int MASK_W         = 4;
   localparam int REQ_W          = 3;
   localparam int INDEX_W        = 3;

   // Request codes; six and seven are unused
   typedef enum logic [REQ_W-1:0] {
      REQ_TICK        = 3'd0,
      REQ_SET_ONCE    = 3'd1,
      REQ_SET_REPEAT  = 3'd2,
      REQ_CANCEL      = 3'd3,
      REQ_READ_TARGET = 3'd4,
      REQ_READ_REMAIN = 3'd5
   } req_code_type;

   typedef enum logic {
      STATUS_OK        = 1'b0,
      STATUS_BAD_INDEX = 1'b1
   } status_type;

   typedef struct packed {
      logic [REQ_W-1:0]    req_type;
      logic [INDEX_W-1:0]  alarm_index;
      logic [PERIOD_W-1:0] interval;
   } req_payload_type;

   typedef struct packed {
      logic [MASK_W-1:0]        fired_mask;
      logic signed [TIME_W-1:0] read_value;
      logic                     status;
      logic [MASK_W-1:0]        active_mask;
   } rsp_payload_type;

endpackage

[sv/mat_stream_if.sv]
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload per transaction
interface mat_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

[sv/multi_alarm_timer.sv]
// multi_alarm_timer: 64-bit tick counter with NUM_ALARMS alarms.
// Path: the request transaction loads the input register, and execution of that
// item then loads the state update and the result register.
// Throughput: one request per cycle; the only stall is a response left untaken.
// Reset (synchronous, active high): time, targets and periods cleared,
// all alarms inactive, both pipeline stages empty.
`timescale 1ns / 1ps

module multi_alarm_timer
   import mat_pkg::*;
#(
   parameter int NUM_ALARMS = NUM_ALARMS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   mat_stream_if.sink   req_if,
   mat_stream_if.source rsp_if
);

   localparam int SEL_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

   // Input stage
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_ff;

   // Result stage
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   // Timer state
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [TIME_W-1:0]   target_ff [NUM_ALARMS];
   logic [TIME_W-1:0]   target_in [NUM_ALARMS];
   logic [PERIOD_W-1:0] period_ff [NUM_ALARMS];
   logic [PERIOD_W-1:0] period_in [NUM_ALARMS];
   logic [NUM_ALARMS-1:0] active_ff, active_in;

   logic                  out_free, exec, req_fire, req_ready;
   logic                  idx_valid;
   logic [SEL_W-1:0]      sel;
   logic [NUM_ALARMS-1:0] fired;
   logic [MASK_W-1:0]     fired_mask, active_mask;
   logic [TIME_W-1:0]     value;
   logic                  status;

   // Handshake: the result register frees the input register
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign exec      = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_if.valid && req_ready;

   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   assign idx_valid = 32'(s1_ff.alarm_index) < NUM_ALARMS;
   assign sel       = idx_valid ? SEL_W'(s1_ff.alarm_index) : '0;

   // Next state and result for the item in the input register
   always_comb begin
      time_in   = time_ff;
      target_in = target_ff;
      period_in = period_ff;
      active_in = active_ff;
      fired     = '0;
      value     = '0;
      status    = STATUS_OK;
      unique case (s1_ff.req_type)
         REQ_TICK: begin
            time_in = time_ff + TIME_W'(1);
            for (int i = 0; i < NUM_ALARMS; i++) begin
               if (active_ff[i] && (target_ff[i] <= time_in)) begin
                  fired[i] = 1'b1;
                  if (period_ff[i] != '0) begin
                     target_in[i] = target_ff[i] + TIME_W'(period_ff[i]);
                  end else begin
                     active_in[i] = 1'b0;
                  end
               end
            end
         end
         REQ_SET_ONCE, REQ_SET_REPEAT: begin
            if (idx_valid) begin
               target_in[sel] = time_ff + TIME_W'(s1_ff.interval);
               period_in[sel] = (s1_ff.req_type == REQ_SET_REPEAT) ? s1_ff.interval : '0;
               active_in[sel] = 1'b1;
            end else begin
               status = STATUS_BAD_INDEX;
            end
         end
         REQ_CANCEL: begin
            if (idx_valid) begin
               active_in[sel] = 1'b0;
            end else begin
               status = STATUS_BAD_INDEX;
            end
         end
         REQ_READ_TARGET: begin
            if (idx_valid) begin
               value = target_ff[sel];
            end else begin
               status = STATUS_BAD_INDEX;
            end
         end
         REQ_READ_REMAIN: begin
            if (!idx_valid) begin
               status = STATUS_BAD_INDEX;
               value  = '1;
            end else if (!active_ff[sel]) begin
               value = '1;
            end else begin
               value = target_ff[sel] - time_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Only the first four alarms show in the masks
   generate
      for (genvar m = 0; m < MASK_W; m++) begin : g_mask
         if (m < NUM_ALARMS) begin : g_on
            assign fired_mask[m]  = fired[m];
            assign active_mask[m] = active_in[m];
         end else begin : g_off
            assign fired_mask[m]  = 1'b0;
            assign active_mask[m] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      rsp_in.fired_mask  = fired_mask;
      rsp_in.read_value  = value;
      rsp_in.status      = status;
      rsp_in.active_mask = active_mask;
   end

   // Pipeline valid bits
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (exec) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= req_if.payload;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   // Timer state, committed when an item executes
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff   <= '0;
         active_ff <= '0;
         for (int i = 0; i < NUM_ALARMS; i++) begin
            target_ff[i] <= '0;
            period_ff[i] <= '0;
         end
      end else if (exec) begin
         time_ff   <= time_in;
         active_ff <= active_in;
         target_ff <= target_in;
         period_ff <= period_in;
      end
   end

endmodule

[sv/mat_checker.sv]
`timescale 1ns / 1ps
`include "multi_alarm_timer_assert.svh"

module mat_checker
   import mat_pkg::*;
(
   input logic          clock,
   input logic          reset,
   mat_stream_if.sink   req_if,
   mat_stream_if.source rsp_if
);

   // A stalled response transaction holds its payload
   `MAT_ASSERT_NXT(a_rsp_hold, rsp_if.valid && !rsp_if.ready,
      rsp_if.valid && $stable(rsp_if.payload), "response changed while stalled")

   // Reset empties the result stage
   `MAT_ASSERT_ANY_NXT(a_reset_empty, reset, !rsp_if.valid, "response valid right after reset")

   // Requests back up only behind an untaken response
   `MAT_ASSERT_IMP(a_stall_cause, !req_if.ready, rsp_if.valid && !rsp_if.ready,
      "request stalled with free output")

   // An index error never comes with fired alarms or a stray read value
   `MAT_ASSERT_IMP(a_error_result, rsp_if.valid && rsp_if.payload.status,
      (rsp_if.payload.fired_mask == '0) &&
      ((rsp_if.payload.read_value == '0) || (&rsp_if.payload.read_value)),
      "bad error response")

endmodule

bind multi_alarm_timer mat_checker u_mat_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import mat_pkg::*;

   // Request codes the block ignores
   localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
   localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

   localparam int STALL_LIMIT = 2000;  // cycles with no transaction before giving up
   localparam int LONG_HOLD   = 300;   // long back-pressure stretch on the response side
   localparam int DRAIN_WAIT  = 8;     // idle wait after the last drain, longer than the pipeline
   localparam int MAX_REPORTS = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mat_stream_if #(.payload_type(req_payload_type)) req_ch ();
   mat_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   multi_alarm_timer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Timer state as the block should hold it
   logic [TIME_W-1:0]   now_ticks;
   logic [TIME_W-1:0]   alarm_due [NUM_ALARMS_DEF];
   logic [PERIOD_W-1:0] alarm_every [NUM_ALARMS_DEF];
   logic                alarm_armed [NUM_ALARMS_DEF];

   req_payload_type pending_req [$];
   rsp_payload_type expected_rsp [$];

   bit src_idle_en = 1'b0;
   bit snk_idle_en = 1'b0;
   int gap_left    = 0;
   int hold_left   = 0;
   int rsp_seen    = 0;
   int errors      = 0;
   int stuck_cycles = 0;

   initial begin
      now_ticks = '0;
      for (int i = 0; i < NUM_ALARMS_DEF; i++) begin
         alarm_due[i]   = '0;
         alarm_every[i] = '0;
         alarm_armed[i] = 1'b0;
      end
   end

   // Apply one request to the timer state and return the response it should give
   function automatic rsp_payload_type advance_timer(req_payload_type r);
      rsp_payload_type o;
      bit              ok;
      int              a;
      o  = '0;
      ok = r.alarm_index < NUM_ALARMS_DEF;
      a  = ok ? int'(r.alarm_index) : 0;
      case (r.req_type)
         REQ_TICK: begin
            now_ticks = now_ticks + 1'b1;
            for (int i = 0; i < NUM_ALARMS_DEF; i++) begin
               if (alarm_armed[i] && alarm_due[i] <= now_ticks) begin
                  if (i < MASK_W) o.fired_mask[i] = 1'b1;
                  // a zero period disarms the alarm once it fires, as for a one-shot
                  if (alarm_every[i] != '0)
                     alarm_due[i] = alarm_due[i] + TIME_W'(alarm_every[i]);
                  else
                     alarm_armed[i] = 1'b0;
               end
            end
         end
         REQ_SET_ONCE, REQ_SET_REPEAT: begin
            if (ok) begin
               alarm_due[a]   = now_ticks + TIME_W'(r.interval);
               alarm_every[a] = (r.req_type == REQ_SET_REPEAT) ? r.interval : '0;
               alarm_armed[a] = 1'b1;
            end else begin
               o.status = STATUS_BAD_INDEX;
            end
         end
         REQ_CANCEL: begin
            if (ok) alarm_armed[a] = 1'b0;
            else o.status = STATUS_BAD_INDEX;
         end
         REQ_READ_TARGET: begin
            if (ok) o.read_value = alarm_due[a];
            else o.status = STATUS_BAD_INDEX;
         end
         REQ_READ_REMAIN: begin
            if (!ok) begin
               o.status     = STATUS_BAD_INDEX;
               o.read_value = '1;
            end else if (!alarm_armed[a]) begin
               o.read_value = '1;
            end else begin
               o.read_value = alarm_due[a] - now_ticks;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < NUM_ALARMS_DEF && i < MASK_W; i++)
         o.active_mask[i] = alarm_armed[i];
      return o;
   endfunction

   // Mostly short pauses, now and then a long one
   function automatic int pick_pause();
      if ($urandom_range(0, 99) < 8) return $urandom_range(4, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic void queue_req(logic [REQ_W-1:0] code, int idx, logic [PERIOD_W-1:0] iv);
      req_payload_type r;
      r.req_type    = code;
      r.alarm_index = idx[INDEX_W-1:0];
      r.interval    = iv;
      pending_req.push_back(r);
   endfunction

   // Ticks dominate so alarms keep firing; short intervals keep targets within reach
   function automatic req_payload_type random_req();
      req_payload_type r;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)      r.req_type = REQ_TICK;
      else if (pick < 57) r.req_type = REQ_SET_ONCE;
      else if (pick < 69) r.req_type = REQ_SET_REPEAT;
      else if (pick < 75) r.req_type = REQ_CANCEL;
      else if (pick < 83) r.req_type = REQ_READ_TARGET;
      else if (pick < 95) r.req_type = REQ_READ_REMAIN;
      else if (pick < 98) r.req_type = REQ_UNUSED_LO;
      else                r.req_type = REQ_UNUSED_HI;
      if ($urandom_range(0, 9) < 9)
         r.alarm_index = INDEX_W'($urandom_range(0, NUM_ALARMS_DEF - 1));
      else
         r.alarm_index = INDEX_W'($urandom_range(NUM_ALARMS_DEF, 7));
      pick = $urandom_range(0, 99);
      if (pick < 70)      r.interval = $urandom_range(0, 20);
      else if (pick < 85) r.interval = $urandom_range(0, 1000);
      else                r.interval = $urandom();
      return r;
   endfunction

   task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic wait_drained();
      while (pending_req.size() != 0 || req_ch.valid || expected_rsp.size() != 0)
         @(negedge clock);
   endtask

   // Request driver; predicts each transaction as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.payload <= '0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_rsp.push_back(advance_timer(req_ch.payload));
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               req_ch.valid   <= 1'b1;
               req_ch.payload <= pending_req.pop_front();
               if (src_idle_en && $urandom_range(0, 99) < 25) gap_left = pick_pause();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor; also throttles ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: response with none expected, actual %h", $time,
                           rsp_ch.payload);
            end else begin
               rsp_payload_type want;
               want = expected_rsp.pop_front();
               check_field("fired_mask", TIME_W'(want.fired_mask),
                           TIME_W'(rsp_ch.payload.fired_mask));
               check_field("read_value", want.read_value, rsp_ch.payload.read_value);
               check_field("status", TIME_W'(want.status), TIME_W'(rsp_ch.payload.status));
               check_field("active_mask", TIME_W'(want.active_mask),
                           TIME_W'(rsp_ch.payload.active_mask));
            end
            // long hold so the pipeline fills and back-pressures the requests
            if (rsp_seen == 600 || rsp_seen == 1500) hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (snk_idle_en && $urandom_range(0, 99) < 20) begin
            hold_left = pick_pause() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("multi_alarm_timer verification failed");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;

      // directed: reset reads, bad indexes, unused codes
      queue_req(REQ_READ_REMAIN, 0, 32'd0);
      queue_req(REQ_READ_TARGET, 3, 32'd0);
      queue_req(REQ_READ_TARGET, 4, 32'd0);
      queue_req(REQ_READ_REMAIN, 7, 32'hFFFF_FFFF);
      queue_req(REQ_UNUSED_LO, 0, 32'd5);
      queue_req(REQ_UNUSED_HI, 7, 32'hFFFF_FFFF);
      // zero-delay one-shot, period one, zero-period repeat, full-scale interval
      queue_req(REQ_SET_ONCE, 0, 32'd0);
      queue_req(REQ_READ_REMAIN, 0, 32'd0);
      queue_req(REQ_SET_REPEAT, 1, 32'd1);
      queue_req(REQ_SET_REPEAT, 2, 32'd0);
      queue_req(REQ_SET_ONCE, 3, 32'hFFFF_FFFF);
      queue_req(REQ_SET_ONCE, 5, 32'd3);
      queue_req(REQ_SET_REPEAT, 6, 32'd3);
      queue_req(REQ_READ_REMAIN, 3, 32'd0);
      queue_req(REQ_TICK, 0, 32'd0);
      queue_req(REQ_TICK, 7, 32'hFFFF_FFFF);
      // cancel keeps the target; inactive reads
      queue_req(REQ_CANCEL, 1, 32'd0);
      queue_req(REQ_CANCEL, 6, 32'd0);
      queue_req(REQ_READ_TARGET, 1, 32'd0);
      queue_req(REQ_READ_REMAIN, 1, 32'd0);
      queue_req(REQ_SET_REPEAT, 3, 32'd2);
      queue_req(REQ_TICK, 0, 32'd0);
      queue_req(REQ_TICK, 0, 32'd0);
      queue_req(REQ_TICK, 0, 32'd0);
      queue_req(REQ_READ_REMAIN, 3, 32'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // random with idling on both sides
      src_idle_en = 1'b1;
      snk_idle_en = 1'b1;
      repeat (1000) pending_req.push_back(random_req());
      wait_drained();

      // back to back, no idling
      src_idle_en = 1'b0;
      snk_idle_en = 1'b0;
      repeat (400) pending_req.push_back(random_req());
      wait_drained();

      src_idle_en = 1'b1;
      snk_idle_en = 1'b1;
      repeat (330) pending_req.push_back(random_req());
      wait_drained();

      repeat (DRAIN_WAIT) @(negedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("multi_alarm_timer verification clean");
      end else begin
         $display("multi_alarm_timer verification failed");
      end
      $finish;
   end

endmodule
